[hdl/assert_macros.svh]
// Assertion macros shared by the graph traversal RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must never hold while out of reset.
`define GDBT_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
// Antecedent must imply consequent in the same cycle.
`define GDBT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");
`else
`define GDBT_ASSERT_NEVER(lbl, clk, rst_n, expr)
`define GDBT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hdl/gdbt_pkg.sv]
package gdbt_pkg;

	localparam int VERT_W = 6;
	localparam int MODE_W = 2;
	localparam int KIND_W = 2;
	localparam int VCNT_W = 7;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_DEGREE_DEF   = 16;

	localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;

	// request modes
	localparam logic [MODE_W-1:0] MODE_EDGE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DFS  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BFS  = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_VISIT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ADDED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DROP  = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [VERT_W-1:0] vertex_a;
		logic [VERT_W-1:0] vertex_b;
	} req_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [VERT_W-1:0] vertex;
		logic              last;
	} rsp_t;

endpackage

[hdl/gdbt_ram.sv]
module gdbt_ram import gdbt_pkg::*; #(
	parameter int WIDTH = VERT_W,
	parameter int DEPTH = MAX_VERTICES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held while idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/graph_dfs_bfs_traversal_unit.sv]
// Channel | Dir | Handshake             | Payload
// req     | in  | req_valid/req_ready   | req_t: mode, vertex_a, vertex_b
// rsp     | out | rsp_valid/rsp_ready   | rsp_t: kind, vertex, last
// cfg     | in  | cfg_valid/cfg_ready   | vertex count, 7 bits
//
// An edge request does two degree reads, then two write-backs if both endpoints
// have room, then the result; an edge with an endpoint out of range goes straight
// to the result. The pace of a traversal is set by the registered reads of the
// degree, neighbour and stack/queue memories.
// arst_n clears degree valid bits, visited marks and control at once; no sweep.
// A full result register stalls the walk only when a result must be reported.
`include "assert_macros.svh"
module graph_dfs_bfs_traversal_unit import gdbt_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [VCNT_W-1:0] cfg_data
);

	localparam int AW  = $clog2(MAX_VERTICES);
	localparam int IW  = $clog2(MAX_DEGREE + 1);
	localparam int SPW = $clog2(MAX_VERTICES + 1);
	localparam int NBD = MAX_VERTICES * MAX_DEGREE;
	localparam int NAW = $clog2(NBD);
	localparam int SCW = VERT_W + IW;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_E_RDB  = 4'd1;
	localparam logic [3:0] ST_E_CHK  = 4'd2;
	localparam logic [3:0] ST_E_WB   = 4'd3;
	localparam logic [3:0] ST_E_OUT  = 4'd4;
	localparam logic [3:0] ST_SCAN   = 4'd5;
	localparam logic [3:0] ST_D_CHK  = 4'd6;
	localparam logic [3:0] ST_D_NB   = 4'd7;
	localparam logic [3:0] ST_D_POP  = 4'd8;
	localparam logic [3:0] ST_B_POPQ = 4'd9;
	localparam logic [3:0] ST_B_U    = 4'd10;
	localparam logic [3:0] ST_B_CHK  = 4'd11;
	localparam logic [3:0] ST_B_NB   = 4'd12;

	function automatic logic [NAW-1:0] nb_addr(input logic [VERT_W-1:0] v,
			input logic [IW-1:0] k);
		return NAW'(v) * NAW'(MAX_DEGREE) + NAW'(k);
	endfunction

	logic [3:0]              state_q;
	logic [VCNT_W-1:0]       vc_q;
	logic [VCNT_W-1:0]       n;
	logic                    bfs_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [MAX_VERTICES-1:0] deg_vld_q;
	logic                    deg_rdv_q;
	logic [VERT_W-1:0]       a_q;
	logic [VERT_W-1:0]       b_q;
	logic [IW-1:0]           deg_a_q;
	logic [IW-1:0]           deg_b_q;
	logic [KIND_W-1:0]       edge_kind_q;
	logic [VCNT_W-1:0]       s_q;
	logic [VERT_W-1:0]       u_q;
	logic [IW-1:0]           i_q;
	logic [SPW-1:0]          sp_q;
	logic [SPW-1:0]          head_q;
	logic [SPW-1:0]          tail_q;
	logic [VCNT_W-1:0]       emit_cnt_q;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	// memory ports
	logic              nb_we, nb_re;
	logic [NAW-1:0]    nb_waddr, nb_raddr;
	logic [VERT_W-1:0] nb_wdata, nb_rdata;
	logic              dg_we, dg_re;
	logic [AW-1:0]     dg_waddr, dg_raddr;
	logic [IW-1:0]     dg_wdata, dg_rdata;
	logic              sc_we, sc_re;
	logic [AW-1:0]     sc_waddr, sc_raddr;
	logic [SCW-1:0]    sc_wdata, sc_rdata;

	// decisions
	logic              out_free;
	logic [IW-1:0]     deg_cur;
	logic              w_new;
	logic              s_new;
	logic              edge_ok;
	logic              emit;
	logic [VERT_W-1:0] emit_v;
	logic              mark_en;
	logic [AW-1:0]     mark_v;
	logic [IW-1:0]     deg_b_eff;
	logic [SPW-1:0]    sp_m1;
	logic [SPW-1:0]    sp_m2;

	gdbt_ram #(.WIDTH(VERT_W), .DEPTH(NBD)) u_nb_ram (
		.clk(clk), .we(nb_we), .waddr(nb_waddr), .wdata(nb_wdata),
		.re(nb_re), .raddr(nb_raddr), .rdata(nb_rdata)
	);

	gdbt_ram #(.WIDTH(IW), .DEPTH(MAX_VERTICES)) u_deg_ram (
		.clk(clk), .we(dg_we), .waddr(dg_waddr), .wdata(dg_wdata),
		.re(dg_re), .raddr(dg_raddr), .rdata(dg_rdata)
	);

	gdbt_ram #(.WIDTH(SCW), .DEPTH(MAX_VERTICES)) u_scratch_ram (
		.clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
		.re(sc_re), .raddr(sc_raddr), .rdata(sc_rdata)
	);

	assign n         = (vc_q > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : vc_q;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign deg_cur   = deg_rdv_q ? dg_rdata : '0;
	assign w_new     = ({1'b0, nb_rdata} < n) && !visited_q[nb_rdata[AW-1:0]];
	assign s_new     = (s_q < n) && !visited_q[s_q[AW-1:0]];
	assign deg_b_eff = (a_q == b_q) ? deg_a_q + IW'(1) : deg_b_q;
	assign sp_m1     = sp_q - SPW'(1);
	assign sp_m2     = sp_q - SPW'(2);

	always_comb begin
		if (a_q == b_q) begin
			edge_ok = ({1'b0, deg_a_q} + (IW+1)'(2)) <= (IW+1)'(MAX_DEGREE);
		end else begin
			edge_ok = (deg_a_q < IW'(MAX_DEGREE)) && (deg_cur < IW'(MAX_DEGREE));
		end
	end

	// memory and result control per state
	always_comb begin
		nb_we = 1'b0; nb_waddr = '0; nb_wdata = '0; nb_re = 1'b0; nb_raddr = '0;
		dg_we = 1'b0; dg_waddr = '0; dg_wdata = '0; dg_re = 1'b0; dg_raddr = '0;
		sc_we = 1'b0; sc_waddr = '0; sc_wdata = '0; sc_re = 1'b0; sc_raddr = '0;
		emit = 1'b0; emit_v = '0; mark_en = 1'b0; mark_v = '0;
		unique case (state_q)
			ST_IDLE: begin
				dg_re    = req_valid && (req.mode == MODE_EDGE);
				dg_raddr = req.vertex_a[AW-1:0];
			end
			ST_E_RDB: begin
				dg_re    = 1'b1;
				dg_raddr = b_q[AW-1:0];
			end
			ST_E_CHK: begin
				nb_we    = edge_ok;
				nb_waddr = nb_addr(a_q, deg_a_q);
				nb_wdata = b_q;
				dg_we    = edge_ok;
				dg_waddr = a_q[AW-1:0];
				dg_wdata = deg_a_q + IW'(1);
			end
			ST_E_WB: begin
				nb_we    = 1'b1;
				nb_waddr = nb_addr(b_q, deg_b_eff);
				nb_wdata = a_q;
				dg_we    = 1'b1;
				dg_waddr = b_q[AW-1:0];
				dg_wdata = deg_b_eff + IW'(1);
			end
			ST_E_OUT: begin
			end
			ST_SCAN: begin
				if (s_new) begin
					if (bfs_q) begin
						mark_en  = 1'b1;
						mark_v   = s_q[AW-1:0];
						sc_we    = 1'b1;
						sc_waddr = '0;
						sc_wdata = SCW'(s_q[VERT_W-1:0]);
					end else if (out_free) begin
						mark_en  = 1'b1;
						mark_v   = s_q[AW-1:0];
						emit     = 1'b1;
						emit_v   = s_q[VERT_W-1:0];
						dg_re    = 1'b1;
						dg_raddr = s_q[AW-1:0];
					end
				end
			end
			ST_D_CHK: begin
				if (i_q < deg_cur) begin
					nb_re    = 1'b1;
					nb_raddr = nb_addr(u_q, i_q);
				end else if (sp_q != SPW'(1)) begin
					sc_re    = 1'b1;
					sc_raddr = sp_m2[AW-1:0];
				end
			end
			ST_D_NB: begin
				if (w_new && (sp_q < SPW'(MAX_VERTICES)) && out_free) begin
					mark_en  = 1'b1;
					mark_v   = nb_rdata[AW-1:0];
					emit     = 1'b1;
					emit_v   = nb_rdata;
					sc_we    = 1'b1;
					sc_waddr = sp_m1[AW-1:0];
					sc_wdata = {u_q, i_q};
					dg_re    = 1'b1;
					dg_raddr = nb_rdata[AW-1:0];
				end
			end
			ST_D_POP: begin
				dg_re    = 1'b1;
				dg_raddr = sc_rdata[IW +: AW];
			end
			ST_B_POPQ: begin
				sc_re    = head_q < tail_q;
				sc_raddr = head_q[AW-1:0];
			end
			ST_B_U: begin
				if (out_free) begin
					emit     = 1'b1;
					emit_v   = sc_rdata[VERT_W-1:0];
					dg_re    = 1'b1;
					dg_raddr = sc_rdata[AW-1:0];
				end
			end
			ST_B_CHK: begin
				nb_re    = i_q < deg_cur;
				nb_raddr = nb_addr(u_q, i_q);
			end
			ST_B_NB: begin
				if (w_new && (tail_q < SPW'(MAX_VERTICES))) begin
					mark_en  = 1'b1;
					mark_v   = nb_rdata[AW-1:0];
					sc_we    = 1'b1;
					sc_waddr = tail_q[AW-1:0];
					sc_wdata = SCW'(nb_rdata);
				end
			end
			default: begin
			end
		endcase
	end

	// degree valid bits, visited marks and degree read tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_vld_q <= '0;
			visited_q <= '0;
			deg_rdv_q <= 1'b0;
		end else begin
			if (dg_we) begin
				deg_vld_q[dg_waddr] <= 1'b1;
			end
			if (dg_re) begin
				deg_rdv_q <= deg_vld_q[dg_raddr];
			end
			if (state_q == ST_IDLE && req_valid &&
					(req.mode inside {MODE_DFS, MODE_BFS})) begin
				visited_q <= '0;
			end else if (mark_en) begin
				visited_q[mark_v] <= 1'b1;
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= VCNT_RESET;
		end else if (cfg_valid) begin
			vc_q <= cfg_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= '{kind: KIND_VISIT, vertex: emit_v,
				last: (emit_cnt_q == n - VCNT_W'(1))};
		end else if (state_q == ST_E_OUT && out_free) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= '{kind: edge_kind_q, vertex: '0, last: 1'b1};
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bfs_q       <= 1'b0;
			s_q         <= '0;
			sp_q        <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			emit_cnt_q  <= '0;
			a_q         <= '0;
			b_q         <= '0;
			deg_a_q     <= '0;
			deg_b_q     <= '0;
			edge_kind_q <= KIND_DROP;
			u_q         <= '0;
			i_q         <= '0;
		end else begin
			if (emit) begin
				emit_cnt_q <= emit_cnt_q + VCNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						a_q        <= req.vertex_a;
						b_q        <= req.vertex_b;
						s_q        <= '0;
						emit_cnt_q <= '0;
						bfs_q      <= req.mode == MODE_BFS;
						unique case (req.mode) inside
							MODE_EDGE: begin
								if (({1'b0, req.vertex_a} < n) && ({1'b0, req.vertex_b} < n)) begin
									state_q <= ST_E_RDB;
								end else begin
									edge_kind_q <= KIND_DROP;
									state_q     <= ST_E_OUT;
								end
							end
							MODE_DFS, MODE_BFS: begin
								state_q <= ST_SCAN;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_E_RDB: begin
					deg_a_q <= deg_cur;
					state_q <= ST_E_CHK;
				end
				ST_E_CHK: begin
					deg_b_q <= deg_cur;
					if (edge_ok) begin
						edge_kind_q <= KIND_ADDED;
						state_q     <= ST_E_WB;
					end else begin
						edge_kind_q <= KIND_DROP;
						state_q     <= ST_E_OUT;
					end
				end
				ST_E_WB: begin
					state_q <= ST_E_OUT;
				end
				ST_E_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (s_q >= n) begin
						state_q <= ST_IDLE;
					end else if (!s_new) begin
						s_q <= s_q + VCNT_W'(1);
					end else if (bfs_q) begin
						head_q  <= '0;
						tail_q  <= SPW'(1);
						state_q <= ST_B_POPQ;
					end else if (out_free) begin
						u_q     <= s_q[VERT_W-1:0];
						i_q     <= '0;
						sp_q    <= SPW'(1);
						state_q <= ST_D_CHK;
					end
				end
				ST_D_CHK: begin
					if (i_q < deg_cur) begin
						i_q     <= i_q + IW'(1);
						state_q <= ST_D_NB;
					end else if (sp_q == SPW'(1)) begin
						sp_q    <= '0;
						s_q     <= s_q + VCNT_W'(1);
						state_q <= ST_SCAN;
					end else begin
						sp_q    <= sp_m1;
						state_q <= ST_D_POP;
					end
				end
				ST_D_NB: begin
					if (!(w_new && (sp_q < SPW'(MAX_VERTICES)))) begin
						state_q <= ST_D_CHK;
					end else if (out_free) begin
						u_q     <= nb_rdata;
						i_q     <= '0;
						sp_q    <= sp_q + SPW'(1);
						state_q <= ST_D_CHK;
					end
				end
				ST_D_POP: begin
					u_q     <= sc_rdata[SCW-1 -: VERT_W];
					i_q     <= sc_rdata[IW-1:0];
					state_q <= ST_D_CHK;
				end
				ST_B_POPQ: begin
					if (head_q < tail_q) begin
						head_q  <= head_q + SPW'(1);
						state_q <= ST_B_U;
					end else begin
						s_q     <= s_q + VCNT_W'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_B_U: begin
					if (out_free) begin
						u_q     <= sc_rdata[VERT_W-1:0];
						i_q     <= '0;
						state_q <= ST_B_CHK;
					end
				end
				ST_B_CHK: begin
					if (i_q < deg_cur) begin
						i_q     <= i_q + IW'(1);
						state_q <= ST_B_NB;
					end else begin
						state_q <= ST_B_POPQ;
					end
				end
				ST_B_NB: begin
					if (w_new && (tail_q < SPW'(MAX_VERTICES))) begin
						tail_q <= tail_q + SPW'(1);
					end
					state_q <= ST_B_CHK;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_ready = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`GDBT_ASSERT_NEVER(a_sp_bound, clk, arst_n, sp_q > SPW'(MAX_VERTICES))
	`GDBT_ASSERT_NEVER(a_queue_order, clk, arst_n, head_q > tail_q)
	`GDBT_ASSERT_NEVER(a_emit_overwrite, clk, arst_n, emit && rsp_valid_q && !rsp_ready)
	`GDBT_ASSERT_IMPLY(a_edge_last, clk, arst_n, rsp_valid_q && rsp_q.kind != KIND_VISIT, rsp_q.last)

endmodule
